// ----- rtl/group_call_register_suffix_match_top_defines.svh -----
// Assertion macros for the group-call register checker.
`ifndef GROUP_CALL_REGISTER_SUFFIX_MATCH_TOP_DEFINES_SVH
`define GROUP_CALL_REGISTER_SUFFIX_MATCH_TOP_DEFINES_SVH

// ante |-> cons, checked at the same edge
`define GCRSM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gcrsm check failed");

// ante |=> cons, cons checked at the following edge
`define GCRSM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gcrsm check failed");

`endif

// ----- rtl/gcrsm_pkg.sv -----
`default_nettype none

package gcrsm_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 16;
    localparam int DEFAULT_MAX_DIGITS  = 8;

    localparam int CMD_W    = 2;
    localparam int TYPE_W   = 4;
    localparam int VAL_W    = 27;
    localparam int DIG_W    = 4;
    localparam int CREF_W   = 32;
    localparam int SLOT_W   = 4;
    localparam int STATUS_W = 2;

    // residue lanes take two call reference bits per cycle
    localparam int SCALE_W    = VAL_W + 2;
    localparam int CREF_STEPS = CREF_W / 2;
    localparam int STEP_W     = $clog2(CREF_STEPS);

    localparam logic [CMD_W-1:0] CMD_CREATE     = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DESTROY    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FIND_GROUP = 2'd2;
    localparam logic [CMD_W-1:0] CMD_FIND_CREF  = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [TYPE_W-1:0] call_type;
        logic [VAL_W-1:0]  group_value;
        logic [DIG_W-1:0]  group_digits;
        logic [SLOT_W-1:0] slot_in;
    } req_t;

    typedef struct packed {
        logic [TYPE_W-1:0] call_type;
        logic [VAL_W-1:0]  value;
        logic [DIG_W-1:0]  digits;
    } entry_t;

    function automatic logic [SCALE_W-1:0] pow10(input int k);
        logic [SCALE_W-1:0] p;
        case (k)
            1:       p = SCALE_W'(10);
            2:       p = SCALE_W'(100);
            3:       p = SCALE_W'(1000);
            4:       p = SCALE_W'(10000);
            5:       p = SCALE_W'(100000);
            6:       p = SCALE_W'(1000000);
            7:       p = SCALE_W'(10000000);
            8:       p = SCALE_W'(100000000);
            default: p = SCALE_W'(1);
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/gcrsm_ram.sv -----
`default_nettype none

module gcrsm_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- rtl/gcrsm_queue.sv -----
`default_nettype none

module gcrsm_queue #(
    parameter int DATA_W = 1
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire logic [DATA_W-1:0] push_data,
    output logic                   full,
    input  wire logic              pop,
    output logic      [DATA_W-1:0] head_data,
    output logic                   empty
);

    logic [DATA_W-1:0] slot_reg [2];
    logic              wr_ptr_reg;
    logic              rd_ptr_reg;
    logic [1:0]        fill_reg;
    logic              do_push;
    logic              do_pop;

    assign full      = fill_reg == 2'd2;
    assign empty     = fill_reg == 2'd0;
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;
    assign head_data = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/gcrsm_front.sv -----
`default_nettype none

module gcrsm_front #(
    parameter int MAX_DIGITS = gcrsm_pkg::DEFAULT_MAX_DIGITS
) (
    input  wire logic                                      clk,
    input  wire logic                                      rst_n,
    input  wire logic                                      in_valid,
    output logic                                           in_stall,
    input  wire logic [gcrsm_pkg::CMD_W-1:0]               command,
    input  wire logic [gcrsm_pkg::TYPE_W-1:0]              call_type,
    input  wire logic [gcrsm_pkg::VAL_W-1:0]               group_value,
    input  wire logic [gcrsm_pkg::DIG_W-1:0]               group_digits,
    input  wire logic [gcrsm_pkg::CREF_W-1:0]              call_reference,
    input  wire logic [gcrsm_pkg::SLOT_W-1:0]              slot_in,
    output logic                                           q_push,
    input  wire logic                                      q_full,
    output gcrsm_pkg::req_t                                q_req,
    output logic [MAX_DIGITS*gcrsm_pkg::VAL_W-1:0]         q_res
);

    localparam int VAL_W   = gcrsm_pkg::VAL_W;
    localparam int CREF_W  = gcrsm_pkg::CREF_W;
    localparam int STEP_W  = gcrsm_pkg::STEP_W;
    localparam int SCALE_W = gcrsm_pkg::SCALE_W;

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_MOD  = 2'd1;
    localparam logic [1:0] F_PUSH = 2'd2;

    logic [1:0]        state_reg;
    logic [1:0]        state_next;
    logic [STEP_W-1:0] step_reg;
    gcrsm_pkg::req_t   req_reg;
    logic [CREF_W-1:0] cref_reg;
    logic [VAL_W-1:0]  res_reg  [MAX_DIGITS];
    logic [VAL_W-1:0]  res_next [MAX_DIGITS];
    logic              accept;

    assign in_stall = state_reg != F_IDLE;
    assign accept   = in_valid && !in_stall;
    assign q_push   = (state_reg == F_PUSH) && !q_full;
    assign q_req    = req_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (command == gcrsm_pkg::CMD_FIND_CREF) ? F_MOD : F_PUSH;
                end
            end
            F_MOD:
            begin
                if (step_reg == '0)
                begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (!q_full)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    // one lane per digit count: remainder by 10^k, two bits in per cycle
    for (genvar g = 0; g < MAX_DIGITS; g++)
    begin : g_lane
        localparam logic [SCALE_W-1:0] M1 = gcrsm_pkg::pow10(g + 1);
        localparam logic [SCALE_W-1:0] M2 = M1 << 1;
        localparam logic [SCALE_W-1:0] M3 = M1 + M2;
        logic [SCALE_W-1:0] t;

        assign t = {res_reg[g], cref_reg[CREF_W-1 -: 2]};
        assign res_next[g] = (t >= M3) ? VAL_W'(t - M3) :
                             (t >= M2) ? VAL_W'(t - M2) :
                             (t >= M1) ? VAL_W'(t - M1) : VAL_W'(t);
        assign q_res[g*VAL_W +: VAL_W] = res_reg[g];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                step_reg <= STEP_W'(gcrsm_pkg::CREF_STEPS - 1);
            end
            else if (state_reg == F_MOD)
            begin
                step_reg <= step_reg - STEP_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg.command      <= command;
            req_reg.call_type    <= call_type;
            req_reg.group_value  <= group_value;
            req_reg.group_digits <= group_digits;
            req_reg.slot_in      <= slot_in;
            cref_reg             <= call_reference;
            for (int i = 0; i < MAX_DIGITS; i++)
            begin
                res_reg[i] <= '0;
            end
        end
        else if (state_reg == F_MOD)
        begin
            cref_reg <= {cref_reg[CREF_W-3:0], 2'b00};
            for (int i = 0; i < MAX_DIGITS; i++)
            begin
                res_reg[i] <= res_next[i];
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/gcrsm_back.sv -----
`default_nettype none

module gcrsm_back #(
    parameter int TABLE_DEPTH = gcrsm_pkg::DEFAULT_TABLE_DEPTH,
    parameter int MAX_DIGITS  = gcrsm_pkg::DEFAULT_MAX_DIGITS
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  q_empty,
    input  wire gcrsm_pkg::req_t                       q_req,
    input  wire logic [MAX_DIGITS*gcrsm_pkg::VAL_W-1:0] q_res,
    output logic                                       q_pop,
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output logic [gcrsm_pkg::STATUS_W-1:0]             status,
    output logic [gcrsm_pkg::SLOT_W-1:0]               slot_out,
    output logic [gcrsm_pkg::DIG_W-1:0]                matched_digits
);

    localparam int VAL_W    = gcrsm_pkg::VAL_W;
    localparam int DIG_W    = gcrsm_pkg::DIG_W;
    localparam int SLOT_W   = gcrsm_pkg::SLOT_W;
    localparam int STATUS_W = gcrsm_pkg::STATUS_W;
    localparam int IDX_W    = $clog2(TABLE_DEPTH);
    localparam int CNT_W    = $clog2(TABLE_DEPTH + 1);
    localparam int ENT_W    = $bits(gcrsm_pkg::entry_t);
    localparam int RAM_W    = ENT_W + IDX_W;

    localparam logic [2:0] B_IDLE = 3'd0;
    localparam logic [2:0] B_FREE = 3'd1;
    localparam logic [2:0] B_DRD  = 3'd2;
    localparam logic [2:0] B_DSWP = 3'd3;
    localparam logic [2:0] B_FIND = 3'd4;
    localparam logic [2:0] B_FRES = 3'd5;
    localparam logic [2:0] B_OUT  = 3'd6;

    logic [2:0]             state_reg;
    logic [2:0]             state_next;
    logic [IDX_W-1:0]       scan_reg;
    logic [CNT_W-1:0]       count_reg;
    logic [TABLE_DEPTH-1:0] valid_reg;
    logic                   found_reg;
    logic [IDX_W-1:0]       best_slot_reg;
    logic [DIG_W-1:0]       best_len_reg;
    logic [IDX_W-1:0]       best_rank_reg;
    logic [IDX_W-1:0]       del_rank_reg;
    logic [STATUS_W-1:0]    status_reg;
    logic [SLOT_W-1:0]      slot_out_reg;
    logic [DIG_W-1:0]       digits_reg;

    logic                   wr_en;
    logic [IDX_W-1:0]       wr_addr;
    logic [RAM_W-1:0]       wr_data;
    logic [IDX_W-1:0]       rd_addr;
    logic [RAM_W-1:0]       rd_data;
    gcrsm_pkg::entry_t      rd_ent;
    logic [IDX_W-1:0]       rd_rank;
    gcrsm_pkg::entry_t      new_ent;

    logic [IDX_W-1:0]       scan_inc;
    logic                   last;
    logic                   full;
    logic [IDX_W-1:0]       slot_idx;
    logic                   slot_live;
    logic                   is_cref;
    logic [VAL_W-1:0]       sel_res;
    logic                   len_ok;
    logic                   type_ok;
    logic                   hit;
    logic                   take;

    gcrsm_ram #(
        .WIDTH (RAM_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_ent   = gcrsm_pkg::entry_t'(rd_data[RAM_W-1 -: ENT_W]);
    assign rd_rank  = rd_data[IDX_W-1:0];
    assign new_ent  = '{call_type: q_req.call_type, value: q_req.group_value,
                        digits: q_req.group_digits};

    assign scan_inc  = scan_reg + IDX_W'(1);
    assign last      = scan_reg == IDX_W'(TABLE_DEPTH - 1);
    assign full      = count_reg == CNT_W'(TABLE_DEPTH);
    assign slot_idx  = IDX_W'(q_req.slot_in);
    assign slot_live = (int'(q_req.slot_in) < TABLE_DEPTH) && valid_reg[slot_idx];
    assign is_cref   = q_req.command == gcrsm_pkg::CMD_FIND_CREF;

    always_comb
    begin
        sel_res = '0;
        for (int g = 0; g < MAX_DIGITS; g++)
        begin
            if (int'(rd_ent.digits) == g + 1)
            begin
                sel_res = q_res[g*VAL_W +: VAL_W];
            end
        end
    end

    assign len_ok  = (rd_ent.digits != '0) && (int'(rd_ent.digits) <= MAX_DIGITS);
    assign type_ok = valid_reg[scan_reg] && (rd_ent.call_type == q_req.call_type);
    assign hit     = type_ok && (is_cref ? (len_ok && rd_ent.value == sel_res)
                                         : (rd_ent.value == q_req.group_value &&
                                            rd_ent.digits == q_req.group_digits));
    assign take    = hit && (!found_reg ||
                             (is_cref && rd_ent.digits > best_len_reg) ||
                             ((!is_cref || rd_ent.digits == best_len_reg) &&
                              rd_rank < best_rank_reg));

    always_comb
    begin
        state_next = state_reg;
        rd_addr    = '0;
        wr_en      = 1'b0;
        wr_addr    = scan_reg;
        wr_data    = {rd_ent, rd_rank - IDX_W'(1)};
        q_pop      = 1'b0;
        case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    case (q_req.command)
                        gcrsm_pkg::CMD_CREATE:
                        begin
                            state_next = full ? B_OUT : B_FREE;
                            q_pop      = full;
                        end
                        gcrsm_pkg::CMD_DESTROY:
                        begin
                            if (slot_live)
                            begin
                                state_next = B_DRD;
                                rd_addr    = slot_idx;
                            end
                            else
                            begin
                                state_next = B_OUT;
                                q_pop      = 1'b1;
                            end
                        end
                        default:
                        begin
                            state_next = B_FIND;
                        end
                    endcase
                end
            end
            B_FREE:
            begin
                if (!valid_reg[scan_reg])
                begin
                    wr_en      = 1'b1;
                    wr_data    = {new_ent, IDX_W'(count_reg)};
                    state_next = B_OUT;
                    q_pop      = 1'b1;
                end
            end
            B_DRD:
            begin
                state_next = B_DSWP;
            end
            B_DSWP:
            begin
                rd_addr = scan_inc;
                wr_en   = valid_reg[scan_reg] && (rd_rank > del_rank_reg);
                if (last)
                begin
                    state_next = B_OUT;
                    q_pop      = 1'b1;
                end
            end
            B_FIND:
            begin
                rd_addr = scan_inc;
                if (last)
                begin
                    state_next = B_FRES;
                end
            end
            B_FRES:
            begin
                state_next = B_OUT;
                q_pop      = 1'b1;
            end
            B_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            scan_reg  <= '0;
            count_reg <= '0;
            valid_reg <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                B_IDLE:
                begin
                    scan_reg  <= '0;
                    found_reg <= 1'b0;
                end
                B_FREE:
                begin
                    if (!valid_reg[scan_reg])
                    begin
                        valid_reg[scan_reg] <= 1'b1;
                        count_reg           <= count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        scan_reg <= scan_inc;
                    end
                end
                B_DRD:
                begin
                    valid_reg[slot_idx] <= 1'b0;
                    count_reg           <= count_reg - CNT_W'(1);
                    scan_reg            <= '0;
                end
                B_DSWP:
                begin
                    scan_reg <= scan_inc;
                end
                B_FIND:
                begin
                    scan_reg <= scan_inc;
                    if (take)
                    begin
                        found_reg <= 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            B_IDLE:
            begin
                if (q_req.command == gcrsm_pkg::CMD_DESTROY)
                begin
                    status_reg   <= gcrsm_pkg::ST_EMPTY;
                    slot_out_reg <= q_req.slot_in;
                end
                else
                begin
                    status_reg   <= gcrsm_pkg::ST_FULL;
                    slot_out_reg <= '0;
                end
                digits_reg <= '0;
            end
            B_FREE:
            begin
                status_reg   <= gcrsm_pkg::ST_OK;
                slot_out_reg <= SLOT_W'(scan_reg);
                digits_reg   <= q_req.group_digits;
            end
            B_DRD:
            begin
                del_rank_reg <= rd_rank;
                status_reg   <= gcrsm_pkg::ST_OK;
                slot_out_reg <= q_req.slot_in;
                digits_reg   <= rd_ent.digits;
            end
            B_FIND:
            begin
                if (take)
                begin
                    best_slot_reg <= scan_reg;
                    best_len_reg  <= rd_ent.digits;
                    best_rank_reg <= rd_rank;
                end
            end
            B_FRES:
            begin
                if (found_reg)
                begin
                    status_reg   <= gcrsm_pkg::ST_OK;
                    slot_out_reg <= SLOT_W'(best_slot_reg);
                    digits_reg   <= best_len_reg;
                end
                else
                begin
                    status_reg   <= gcrsm_pkg::ST_NOT_FOUND;
                    slot_out_reg <= '0;
                    digits_reg   <= '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid      = state_reg == B_OUT;
    assign status         = status_reg;
    assign slot_out       = slot_out_reg;
    assign matched_digits = digits_reg;

endmodule

`default_nettype wire

// ----- rtl/group_call_register_suffix_match_top.sv -----
`default_nettype none

// Group-call register: a table of TABLE_DEPTH entries, each a call type, a decimal group
// number and its digit count. Commands are create (lowest free slot), destroy (by slot),
// find by group (exact match, earliest inserted wins) and find by call reference (entry
// value equals call_reference mod 10^digits, most digits then earliest inserted wins).
// One result item per input item, in order. The front holds off new items while busy; a
// find by call reference first stays there to reduce the reference two bits per cycle in
// one remainder lane per digit count. A two-entry queue lets the front work on the next
// item while the back runs the table. The back reads one table entry per cycle through
// the table RAM's single read port: a find or a destroy walks all TABLE_DEPTH entries,
// a create scans up to the lowest free slot, and a full-table create or destroy of an
// empty slot reads no entry; each result then waits under out_stall. The valid bits
// clear at reset, so the block takes items right after reset.
module group_call_register_suffix_match_top #(
    parameter int TABLE_DEPTH = gcrsm_pkg::DEFAULT_TABLE_DEPTH,
    parameter int MAX_DIGITS  = gcrsm_pkg::DEFAULT_MAX_DIGITS
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [gcrsm_pkg::CMD_W-1:0]       command,
    input  wire logic [gcrsm_pkg::TYPE_W-1:0]      call_type,
    input  wire logic [gcrsm_pkg::VAL_W-1:0]       group_value,
    input  wire logic [gcrsm_pkg::DIG_W-1:0]       group_digits,
    input  wire logic [gcrsm_pkg::CREF_W-1:0]      call_reference,
    input  wire logic [gcrsm_pkg::SLOT_W-1:0]      slot_in,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [gcrsm_pkg::STATUS_W-1:0]         status,
    output logic [gcrsm_pkg::SLOT_W-1:0]           slot_out,
    output logic [gcrsm_pkg::DIG_W-1:0]            matched_digits
);

    localparam int REQ_W = $bits(gcrsm_pkg::req_t);
    localparam int RES_W = MAX_DIGITS * gcrsm_pkg::VAL_W;
    localparam int Q_W   = REQ_W + RES_W;

    logic              f_push;
    logic              q_full;
    gcrsm_pkg::req_t   f_req;
    logic [RES_W-1:0]  f_res;
    logic [Q_W-1:0]    head_data;
    logic              q_empty;
    logic              q_pop;
    gcrsm_pkg::req_t   h_req;
    logic [RES_W-1:0]  h_res;

    gcrsm_front #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .command        (command),
        .call_type      (call_type),
        .group_value    (group_value),
        .group_digits   (group_digits),
        .call_reference (call_reference),
        .slot_in        (slot_in),
        .q_push         (f_push),
        .q_full         (q_full),
        .q_req          (f_req),
        .q_res          (f_res)
    );

    gcrsm_queue #(
        .DATA_W (Q_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (f_push),
        .push_data ({f_req, f_res}),
        .full      (q_full),
        .pop       (q_pop),
        .head_data (head_data),
        .empty     (q_empty)
    );

    assign h_req = gcrsm_pkg::req_t'(head_data[Q_W-1 -: REQ_W]);
    assign h_res = head_data[RES_W-1:0];

    gcrsm_back #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .MAX_DIGITS  (MAX_DIGITS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_empty        (q_empty),
        .q_req          (h_req),
        .q_res          (h_res),
        .q_pop          (q_pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .slot_out       (slot_out),
        .matched_digits (matched_digits)
    );

endmodule

`default_nettype wire

// ----- rtl/gcrsm_checker.sv -----
`default_nettype none

`include "group_call_register_suffix_match_top_defines.svh"

module gcrsm_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              out_valid,
    input wire logic                              out_stall,
    input wire logic [gcrsm_pkg::STATUS_W-1:0]    status,
    input wire logic [gcrsm_pkg::SLOT_W-1:0]      slot_out,
    input wire logic [gcrsm_pkg::DIG_W-1:0]       matched_digits
);

    `GCRSM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
    `GCRSM_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(status) && $stable(slot_out) && $stable(matched_digits))
    `GCRSM_ASSERT_NOW(a_miss_zero, clk, rst_n, out_valid && (status == gcrsm_pkg::ST_FULL || status == gcrsm_pkg::ST_NOT_FOUND), slot_out == '0 && matched_digits == '0)
    `GCRSM_ASSERT_NOW(a_empty_zero, clk, rst_n, out_valid && status == gcrsm_pkg::ST_EMPTY, matched_digits == '0)
    `GCRSM_ASSERT_NEXT(a_out_drop, clk, rst_n, out_valid && !out_stall, !out_valid)

endmodule

bind group_call_register_suffix_match_top gcrsm_checker u_gcrsm_checker (.*);

`default_nettype wire
